### rtl/mie_pkg.sv
// Shared types, opcodes and sizes for the I-type execute block.
package mie_pkg;

   localparam int MEM_WORDS = 1024;   // power of two
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int RF_DEPTH  = 32;
   localparam int RF_AW     = $clog2(RF_DEPTH);
   localparam int WORD_W    = 32;
   localparam int PC_W      = 30;
   localparam int MIDX_W    = 10;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam int RSP_BITS    = PC_W + 1 + RF_AW + WORD_W + 1 + MIDX_W + WORD_W + 1 + 1;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD     = RSP_TDATA_W - RSP_BITS;

   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTI  = 6'h0a;
   localparam logic [5:0] OP_SLTIU = 6'h0b;
   localparam logic [5:0] OP_ANDI  = 6'h0c;
   localparam logic [5:0] OP_ORI   = 6'h0d;
   localparam logic [5:0] OP_LUI   = 6'h0f;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SW    = 6'h2b;

   // first member lands in the highest bits
   typedef struct packed {
      logic              unknown_opcode;
      logic              branch_taken;
      logic [WORD_W-1:0] mem_data;
      logic [MIDX_W-1:0] mem_index;
      logic              mem_write;
      logic [WORD_W-1:0] reg_value;
      logic [RF_AW-1:0]  reg_index;
      logic              reg_write;
      logic [PC_W-1:0]   next_pc;
   } rsp_type;

   typedef struct packed {
      rsp_type           res;
      logic              is_load;
      logic [MEM_AW-1:0] mem_addr;
   } exec_type;

endpackage

### rtl/mips_itype_execute.sv
// Top level of the MIPS I-type execute block: register file, data memory, pipeline.
// An accepted instruction passes through stage 1, stage 2 and the result queue before its result can be taken.
// Throughput: one instruction per cycle; register and load results are forwarded.
// It holds while queued results plus both stages' instructions stay below 4 queue entries.
// Reset: register file reads as zero at once (per-entry valid bits); the data memory is
// cleared by a pass over all MEM_WORDS (1024) words, during which req_tready stays low.
module mips_itype_execute (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,  // [31:0] instruction
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [29:0] next_pc, [30] reg_write, [35:31] reg_index, [67:36] reg_value,
   // [68] mem_write, [78:69] mem_index, [110:79] mem_data, [111] branch_taken,
   // [112] unknown_opcode, rest zero
   output logic [mie_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import mie_pkg::*;

   logic                 req_accept;
   logic                 clearing_ff, clearing_in;
   logic [MEM_AW-1:0]    clr_ff, clr_in;

   logic                 s1_valid_ff;
   logic [31:0]          s1_instr_ff;
   logic [RF_AW-1:0]     s1_rs;
   logic [RF_AW-1:0]     s1_rt;
   logic [WORD_W-1:0]    rf_a_rdata, rf_b_rdata;
   logic [WORD_W-1:0]    op_a, op_b;
   exec_type             s1_exec;

   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [RF_DEPTH-1:0]  rf_valid_ff, rf_valid_in;

   logic                 s2_valid_ff;
   exec_type             s2_exec_ff;
   logic [WORD_W-1:0]    dm_rdata;
   rsp_type              s2_res;

   logic                 rf_we;
   logic                 wb_valid_ff;
   logic [RF_AW-1:0]     wb_idx_ff;
   logic [WORD_W-1:0]    wb_val_ff;

   logic                 dm_we;
   logic [MEM_AW-1:0]    dm_waddr;
   logic [WORD_W-1:0]    dm_wdata;

   logic                 q_pop;
   rsp_type              q_data;
   logic [FIFO_CW-1:0]   q_count;
   logic [FIFO_CW:0]     inflight;

   function automatic logic [WORD_W-1:0] fwd(
      input logic [RF_AW-1:0]  idx,
      input logic [WORD_W-1:0] ram_val
   );
      logic [WORD_W-1:0] r;
      if (idx == '0) begin
         r = '0;
      end else if (s2_valid_ff && s2_res.reg_write && s2_res.reg_index == idx) begin
         r = s2_res.reg_value;
      end else if (wb_valid_ff && wb_idx_ff == idx) begin
         r = wb_val_ff;
      end else if (rf_valid_ff[idx]) begin
         r = ram_val;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   assign inflight   = (FIFO_CW+1)'(q_count) + (FIFO_CW+1)'(s1_valid_ff)
                       + (FIFO_CW+1)'(s2_valid_ff);
   assign req_tready = !clearing_ff && (inflight < (FIFO_CW+1)'(FIFO_DEPTH));
   assign req_accept = req_tvalid && req_tready;

   // clearing pass over the data memory
   always_comb begin
      clr_in      = clr_ff + MEM_AW'(1);
      clearing_in = clearing_ff && (clr_ff != MEM_AW'(MEM_WORDS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else if (clearing_ff) begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
      end
   end

   // stage 1: operands arrive from the register file
   mie_ram #(.WIDTH(WORD_W), .DEPTH(RF_DEPTH)) u_rf_a (
      .clock (clock),
      .we    (rf_we),
      .waddr (s2_res.reg_index),
      .wdata (s2_res.reg_value),
      .raddr (req_tdata[25:21]),
      .rdata (rf_a_rdata)
   );

   mie_ram #(.WIDTH(WORD_W), .DEPTH(RF_DEPTH)) u_rf_b (
      .clock (clock),
      .we    (rf_we),
      .waddr (s2_res.reg_index),
      .wdata (s2_res.reg_value),
      .raddr (req_tdata[20:16]),
      .rdata (rf_b_rdata)
   );

   assign s1_rs = s1_instr_ff[25:21];
   assign s1_rt = s1_instr_ff[20:16];

   always_comb begin
      op_a = fwd(s1_rs, rf_a_rdata);
      op_b = fwd(s1_rt, rf_b_rdata);
   end

   mie_alu u_alu (
      .instruction (s1_instr_ff),
      .a           (op_a),
      .b           (op_b),
      .pc          (pc_ff),
      .exec        (s1_exec)
   );

   assign pc_in = s1_valid_ff ? s1_exec.res.next_pc : pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
         pc_ff       <= '0;
         rf_valid_ff <= '0;
      end else begin
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
         wb_valid_ff <= rf_we;
         pc_ff       <= pc_in;
         rf_valid_ff <= rf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_instr_ff <= req_tdata;
      end
      s2_exec_ff <= s1_exec;
      wb_idx_ff  <= s2_res.reg_index;
      wb_val_ff  <= s2_res.reg_value;
   end

   // data memory: stores and load reads issue from stage 1
   always_comb begin
      dm_we    = clearing_ff || (s1_valid_ff && s1_exec.res.mem_write);
      dm_waddr = clearing_ff ? clr_ff : s1_exec.mem_addr;
      dm_wdata = clearing_ff ? '0 : op_b;
   end

   mie_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_dmem (
      .clock (clock),
      .we    (dm_we),
      .waddr (dm_waddr),
      .wdata (dm_wdata),
      .raddr (s1_exec.mem_addr),
      .rdata (dm_rdata)
   );

   // stage 2: merge load data, write back
   always_comb begin
      s2_res = s2_exec_ff.res;
      if (s2_exec_ff.is_load) begin
         s2_res.reg_value = dm_rdata;
      end
   end

   assign rf_we = s2_valid_ff && s2_res.reg_write;

   always_comb begin
      rf_valid_in = rf_valid_ff;
      if (rf_we) begin
         rf_valid_in[s2_res.reg_index] = 1'b1;
      end
   end

   assign q_pop = rsp_tvalid && rsp_tready;

   mie_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (s2_res),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_data  (q_data),
      .count     (q_count)
   );

   assign rsp_tdata = {{RSP_PAD{1'b0}}, q_data};

   assert property (@(posedge clock) disable iff (reset) clearing_ff |-> !req_tready)
      else $error("input taken during memory clear");

   assert property (@(posedge clock) disable iff (reset)
      inflight <= (FIFO_CW+1)'(FIFO_DEPTH))
      else $error("result queue overcommitted");

   assert property (@(posedge clock) disable iff (reset)
      rf_we |-> (s2_res.reg_index != '0))
      else $error("register zero written");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_exec.res.unknown_opcode) |=> (pc_ff == $past(pc_ff)))
      else $error("pc moved on unknown opcode");

endmodule

### rtl/mie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/mie_alu.sv
// Decode and execute of one I-type instruction against forwarded operands.
module mie_alu (
   input  logic [31:0]                instruction,
   input  logic [mie_pkg::WORD_W-1:0] a,
   input  logic [mie_pkg::WORD_W-1:0] b,
   input  logic [mie_pkg::PC_W-1:0]   pc,
   output mie_pkg::exec_type          exec
);
   import mie_pkg::*;

   logic [5:0]        op;
   logic [RF_AW-1:0]  rt;
   logic [15:0]       imm;
   logic [WORD_W-1:0] simm;
   logic [WORD_W-1:0] zimm;
   logic [WORD_W-1:0] sum;
   logic [WORD_W-1:0] midx_wide;
   logic [PC_W-1:0]   pc_inc;
   logic [PC_W-1:0]   pc_br;
   logic              wr;
   logic [WORD_W-1:0] val;

   assign op        = instruction[31:26];
   assign rt        = instruction[20:16];
   assign imm       = instruction[15:0];
   assign simm      = {{(WORD_W-16){imm[15]}}, imm};
   assign zimm      = {{(WORD_W-16){1'b0}}, imm};
   assign sum       = a + simm;
   assign midx_wide = {{(WORD_W-MEM_AW){1'b0}}, sum[MEM_AW-1:0]};
   assign pc_inc    = pc + PC_W'(1);
   assign pc_br     = pc_inc + simm[PC_W-1:0];

   always_comb begin
      exec     = '0;
      wr       = 1'b0;
      val      = '0;
      exec.res.next_pc = pc_inc;
      unique case (op) inside
         OP_ADDI, OP_ADDIU: begin
            wr  = 1'b1;
            val = sum;
         end
         OP_ANDI: begin
            wr  = 1'b1;
            val = a & zimm;
         end
         OP_ORI: begin
            wr  = 1'b1;
            val = a | zimm;
         end
         OP_LUI: begin
            wr  = 1'b1;
            val = {imm, 16'h0000};
         end
         OP_SLTI: begin
            wr  = 1'b1;
            val = {{(WORD_W-1){1'b0}}, ($signed(a) < $signed(simm))};
         end
         OP_SLTIU: begin
            wr  = 1'b1;
            val = {{(WORD_W-1){1'b0}}, (a < simm)};
         end
         OP_LW: begin
            wr = 1'b1;
            exec.res.mem_index = midx_wide[MIDX_W-1:0];
            exec.mem_addr      = sum[MEM_AW-1:0];
            exec.is_load       = (rt != '0);
         end
         OP_SW: begin
            exec.res.mem_index = midx_wide[MIDX_W-1:0];
            exec.res.mem_write = 1'b1;
            exec.res.mem_data  = b;
            exec.mem_addr      = sum[MEM_AW-1:0];
         end
         OP_BEQ, OP_BNE: begin
            exec.res.branch_taken = (op == OP_BEQ) ? (a == b) : (a != b);
            if (exec.res.branch_taken) begin
               exec.res.next_pc = pc_br;
            end
         end
         default: begin
            exec.res.unknown_opcode = 1'b1;
            exec.res.next_pc        = pc;
         end
      endcase
      if (wr && rt != '0) begin
         exec.res.reg_write = 1'b1;
         exec.res.reg_index = rt;
         exec.res.reg_value = val;
      end
   end

endmodule

### rtl/mie_fifo.sv
// Result queue between the execute pipeline and the result channel.
module mie_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mie_pkg::rsp_type            push_data,
   input  logic                        pop,
   output logic                        out_valid,
   output mie_pkg::rsp_type            out_data,
   output logic [mie_pkg::FIFO_CW-1:0] count
);
   import mie_pkg::*;

   rsp_type              entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### tb/itype_execute_checker.sv
// Checker for the I-type execute block: predicts each result beat and compares it field by field.
module itype_execute_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [31:0]                     req_tdata,    // [31:0] instruction
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // next_pc up to unknown_opcode, then zero padding
   input  logic [mie_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                              error_count,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import mie_pkg::*;

   logic [WORD_W-1:0] gpr [RF_DEPTH];
   logic [WORD_W-1:0] dmem [MEM_WORDS];
   logic [PC_W-1:0]   pc;
   rsp_type           predicted_results [$];
   rsp_type           observed;
   rsp_type           want;

   function automatic rsp_type execute_word(input logic [31:0] word);
      logic [5:0]        opcode;
      logic [4:0]        rs;
      logic [4:0]        rt;
      logic [15:0]       imm;
      logic [WORD_W-1:0] simm;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] ea;
      logic [PC_W-1:0]   nxt;
      logic              writes;
      rsp_type           r;
      opcode = word[31:26];
      rs     = word[25:21];
      rt     = word[20:16];
      imm    = word[15:0];
      simm   = {{16{imm[15]}}, imm};
      a      = gpr[rs];
      b      = gpr[rt];
      ea     = a + simm;
      nxt    = pc + 1'b1;
      value  = '0;
      writes = 1'b0;
      r      = '0;
      case (opcode)
         OP_ADDI, OP_ADDIU: begin
            value  = a + simm;
            writes = 1'b1;
         end
         OP_ANDI: begin
            value  = a & {16'h0000, imm};
            writes = 1'b1;
         end
         OP_ORI: begin
            value  = a | {16'h0000, imm};
            writes = 1'b1;
         end
         OP_LUI: begin
            value  = {imm, 16'h0000};
            writes = 1'b1;
         end
         OP_SLTI: begin
            value  = 32'($signed(a) < $signed(simm));
            writes = 1'b1;
         end
         OP_SLTIU: begin
            value  = 32'(a < simm);
            writes = 1'b1;
         end
         OP_LW: begin
            r.mem_index = MIDX_W'(ea[MEM_AW-1:0]);
            value       = dmem[ea[MEM_AW-1:0]];
            writes      = 1'b1;
         end
         OP_SW: begin
            r.mem_index         = MIDX_W'(ea[MEM_AW-1:0]);
            dmem[ea[MEM_AW-1:0]] = b;
            r.mem_data          = b;
            r.mem_write         = 1'b1;
         end
         OP_BEQ, OP_BNE: begin
            r.branch_taken = (opcode == OP_BEQ) ? (a == b) : (a != b);
            if (r.branch_taken) begin
               nxt = pc + 1'b1 + simm[PC_W-1:0];
            end
         end
         default: begin
            r.unknown_opcode = 1'b1;
            nxt              = pc;
         end
      endcase
      if (writes && rt != '0) begin
         gpr[rt]     = value;
         r.reg_write = 1'b1;
         r.reg_index = rt;
         r.reg_value = value;
      end
      pc        = nxt;
      r.next_pc = nxt;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [WORD_W-1:0] expected_value,
                              input logic [WORD_W-1:0] actual_value);
      if (expected_value !== actual_value) begin
         error_count++;
         if (error_count <= 10) begin
            $display("mismatch in %s: expected %h, got %h", field, expected_value, actual_value);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (gpr[i]) gpr[i] = '0;
         foreach (dmem[i]) dmem[i] = '0;
         pc = '0;
         predicted_results.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_results.push_back(execute_word(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            observed = rsp_type'(rsp_tdata[RSP_BITS-1:0]);
            if (predicted_results.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("result beat with nothing expected: %h", rsp_tdata);
               end
            end else begin
               want = predicted_results.pop_front();
               check_field("next_pc", want.next_pc, observed.next_pc);
               check_field("reg_write", want.reg_write, observed.reg_write);
               check_field("reg_index", want.reg_index, observed.reg_index);
               check_field("reg_value", want.reg_value, observed.reg_value);
               check_field("mem_write", want.mem_write, observed.mem_write);
               check_field("mem_index", want.mem_index, observed.mem_index);
               check_field("mem_data", want.mem_data, observed.mem_data);
               check_field("branch_taken", want.branch_taken, observed.branch_taken);
               check_field("unknown_opcode", want.unknown_opcode, observed.unknown_opcode);
               check_field("padding", '0, rsp_tdata[RSP_TDATA_W-1:RSP_BITS]);
            end
         end
      end
      outstanding <= predicted_results.size();
   end

endmodule

### tb/testbench.sv
// Top of the I-type execute testbench: clock, reset, instruction stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mie_pkg::*;

   localparam int RANDOM_PER_PHASE = 430;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int DRAIN_CYCLES     = 8;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [31:0]            req_tdata  = '0;
   logic                   rsp_tready = 1'b0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   int                     error_count;
   int                     outstanding;
   int                     tx_idle_pct = 28;
   int                     rx_idle_pct = 74;
   int                     cycle_count = 0;

   logic [5:0] known_ops [11] = '{OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
                                  OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_SW};

   // opcode, rs, rt, immediate
   logic [31:0] directed_words [24] = '{
      {OP_ORI,   5'd0,  5'd1,  16'hFFFF},
      {OP_LUI,   5'd31, 5'd2,  16'h8000},
      {OP_ADDI,  5'd2,  5'd3,  16'hFFFF},
      {OP_ADDIU, 5'd3,  5'd4,  16'h0001},
      {OP_ANDI,  5'd1,  5'd5,  16'h8001},
      {OP_SLTI,  5'd2,  5'd6,  16'h0000},
      {OP_SLTI,  5'd3,  5'd7,  16'h7FFF},
      {OP_SLTIU, 5'd2,  5'd8,  16'hFFFF},
      {OP_SLTIU, 5'd0,  5'd9,  16'h8000},
      {OP_SW,    5'd0,  5'd1,  16'h0000},
      {OP_SW,    5'd0,  5'd2,  16'h03FF},
      {OP_SW,    5'd0,  5'd3,  16'hFFFF},
      {OP_LW,    5'd0,  5'd10, 16'h03FF},
      {OP_LW,    5'd2,  5'd11, 16'h7FFF},
      {OP_LW,    5'd0,  5'd0,  16'h0000},
      {OP_ADDI,  5'd1,  5'd0,  16'h0005},
      {OP_BEQ,   5'd0,  5'd0,  16'h0003},
      {OP_BNE,   5'd0,  5'd0,  16'h0003},
      {OP_BEQ,   5'd1,  5'd2,  16'h0004},
      {OP_BNE,   5'd1,  5'd2,  16'hFFF6},
      {OP_BEQ,   5'd0,  5'd0,  16'h8000},
      32'h0000_0000,
      32'hFFFF_FFFF,
      {OP_SW,    5'd31, 5'd31, 16'h7FFF}
   };

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   mips_itype_execute DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   itype_execute_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   function automatic logic [31:0] random_instruction();
      int          pick;
      logic [5:0]  op;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [15:0] imm;
      pick = $urandom_range(99);
      if (pick < 8) begin
         return $urandom();
      end
      if (pick < 12) begin
         do begin
            op = 6'($urandom_range(63));
         end while (op inside {OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
                               OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_SW});
         return {op, 26'($urandom())};
      end
      if (pick < 35) begin
         op = $urandom_range(1) ? OP_SW : OP_LW;
      end else begin
         op = known_ops[$urandom_range(10)];
      end
      rs = ($urandom_range(9) < 6) ? 5'($urandom_range(7)) : 5'($urandom());
      rt = ($urandom_range(9) < 6) ? 5'($urandom_range(7)) : 5'($urandom());
      case ($urandom_range(3))
         0: imm = 16'($urandom());
         1: begin
            case ($urandom_range(3))
               0: imm = 16'h0000;
               1: imm = 16'h7FFF;
               2: imm = 16'h8000;
               default: imm = 16'hFFFF;
            endcase
         end
         default: imm = 16'($urandom_range(16)) - 16'd8;
      endcase
      // keep loads and stores near absolute low addresses so they meet again
      if ((op == OP_LW || op == OP_SW) && $urandom_range(1)) begin
         rs = '0;
      end
      return {op, rs, rt, imm};
   endfunction

   task automatic send(input logic [31:0] word);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[mips_itype_execute] ERROR");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_words[i]) send(directed_words[i]);
      repeat (RANDOM_PER_PHASE) send(random_instruction());
      // hold the sender until the pipeline has drained
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      tx_idle_pct = 74;
      rx_idle_pct = 28;
      repeat (RANDOM_PER_PHASE) send(random_instruction());
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (RANDOM_PER_PHASE) send(random_instruction());
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("[mips_itype_execute] OK");
      end else begin
         $display("[mips_itype_execute] ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/mie_pkg.sv
rtl/mie_ram.sv
rtl/mie_alu.sv
rtl/mie_fifo.sv
rtl/mips_itype_execute.sv
tb/itype_execute_checker.sv
tb/testbench.sv
